// ----- rtl/core/pac_pkg.sv -----
//------------------------------------------------------------------------------
// pac_pkg
// Shared types, constants and helpers for the PMP access check.
//------------------------------------------------------------------------------
`default_nettype none

package pac_pkg;

   // Default number of protection entries (one cell each).
   localparam int PAC_ENTRIES = 8;

   // Widths of the fixed fields.
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 4;
   localparam int PRIV_W  = 2;
   localparam int KIND_W  = 2;
   localparam int HIT_W   = 4;
   localparam int CSR_AW  = 6;
   localparam int CSR_DW  = 64;
   localparam int PAIRS   = 4;

   // Access kinds; any other code is handled as a store.
   localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;

   // Machine privilege level.
   localparam logic [PRIV_W-1:0] PRIV_M = 2'd3;

   // Reported entry when no entry matched.
   localparam logic [HIT_W-1:0] NO_HIT = 4'd8;

   // Word bounds at or above this limit saturate to the top byte.
   localparam int WORD_LIMIT_SHIFT = 30;
   localparam logic [ADDR_W-1:0] TOP_BYTE = 32'hFFFF_FFFF;

   // Bit positions inside one entry configuration byte.
   localparam int CFG_R_BIT = 0;
   localparam int CFG_W_BIT = 1;
   localparam int CFG_X_BIT = 2;
   localparam int CFG_L_BIT = 7;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_CFG_BYTES  = 3'd0;
   localparam logic [2:0] REG_ADDR_PAIR0 = 3'd1;
   localparam logic [2:0] REG_ADDR_PAIR1 = 3'd2;
   localparam logic [2:0] REG_ADDR_PAIR2 = 3'd3;
   localparam logic [2:0] REG_ADDR_PAIR3 = 3'd4;

   // Address matching modes.
   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_TOR   = 2'd1,
      MODE_NA4   = 2'd2,
      MODE_NAPOT = 2'd3
   } pac_mode_type;

   // Configuration register contents.
   typedef struct packed {
      logic [CSR_DW-1:0]            cfg_bytes;
      logic [PAIRS-1:0][CSR_DW-1:0] addr_pair;
   } pac_regs_type;

   // One access travelling down the row of cells.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] last;
      logic [PRIV_W-1:0] eff;
      logic              done;
      logic              ok;
      logic [HIT_W-1:0]  hit;
   } pac_item_type;

   // Converts a word bound to a byte bound, saturating large values.
   function automatic logic [ADDR_W-1:0] to_bytes(input logic [ADDR_W:0] words);
      logic [ADDR_W-1:0] result;
      if (words[ADDR_W:WORD_LIMIT_SHIFT] != '0) begin
         result = TOP_BYTE;
      end else begin
         result = {words[WORD_LIMIT_SHIFT-1:0], 2'b00};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pac_csr.sv -----
//------------------------------------------------------------------------------
// pac_csr
// APB register file holding the entry configuration and address words.
//------------------------------------------------------------------------------
`default_nettype none

module pac_csr
   import pac_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output pac_regs_type           regs
);

   pac_regs_type regs_ff;
   pac_regs_type regs_in;
   logic [2:0]   index;

   // Registers sit on 8-byte boundaries.
   assign index      = csr_paddr[CSR_AW-1:3];
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   // Write decode; writes past the last register are dropped.
   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (index)
            REG_CFG_BYTES:  regs_in.cfg_bytes    = csr_pwdata;
            REG_ADDR_PAIR0: regs_in.addr_pair[0] = csr_pwdata;
            REG_ADDR_PAIR1: regs_in.addr_pair[1] = csr_pwdata;
            REG_ADDR_PAIR2: regs_in.addr_pair[2] = csr_pwdata;
            REG_ADDR_PAIR3: regs_in.addr_pair[3] = csr_pwdata;
            default:        regs_in = regs_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (index)
         REG_CFG_BYTES:  csr_prdata = regs_ff.cfg_bytes;
         REG_ADDR_PAIR0: csr_prdata = regs_ff.addr_pair[0];
         REG_ADDR_PAIR1: csr_prdata = regs_ff.addr_pair[1];
         REG_ADDR_PAIR2: csr_prdata = regs_ff.addr_pair[2];
         REG_ADDR_PAIR3: csr_prdata = regs_ff.addr_pair[3];
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/pac_cell.sv -----
//------------------------------------------------------------------------------
// pac_cell
// One protection entry: decodes its range and checks the passing access.
//------------------------------------------------------------------------------
`default_nettype none

module pac_cell
   import pac_pkg::*;
#(
   parameter int INDEX = 0
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        cfg_byte,
   input  wire logic [ADDR_W-1:0] word,
   input  wire logic [ADDR_W-1:0] prev_word,
   input  wire logic              in_valid,
   input  pac_item_type           in_item,
   output logic                   in_ready,
   output logic                   out_valid,
   output pac_item_type           out_item,
   input  wire logic              out_ready
);

   pac_mode_type      mode;
   logic [ADDR_W-1:0] napot_mask;
   logic [ADDR_W-1:0] napot_base;
   logic [ADDR_W:0]   napot_top;
   logic              on_in;
   logic [ADDR_W-1:0] lo_in;
   logic [ADDR_W-1:0] hi_in;
   logic              on_ff;
   logic [ADDR_W-1:0] lo_ff;
   logic [ADDR_W-1:0] hi_ff;
   logic              hit_here;
   logic              ok_here;
   logic              valid_ff;
   pac_item_type      item_ff;
   pac_item_type      item_in;

   assign mode = pac_mode_type'(cfg_byte[4:3]);

   // A NAPOT word's trailing ones plus the next bit form the size mask.
   assign napot_mask = word ^ (word + ADDR_W'(1));
   assign napot_base = word & ~napot_mask;
   assign napot_top  = {1'b0, napot_base} + {1'b0, napot_mask} + (ADDR_W+1)'(1);

   // Byte range of this entry, decoded from the registers.
   always_comb begin
      on_in = 1'b0;
      lo_in = '0;
      hi_in = '0;
      case (mode)
         MODE_TOR: begin
            on_in = word > prev_word;
            lo_in = to_bytes({1'b0, prev_word});
            hi_in = to_bytes({1'b0, word});
         end
         MODE_NA4: begin
            on_in = 1'b1;
            lo_in = to_bytes({1'b0, word});
            hi_in = to_bytes({1'b0, word} + (ADDR_W+1)'(1));
         end
         MODE_NAPOT: begin
            on_in = 1'b1;
            lo_in = to_bytes({1'b0, napot_base});
            hi_in = to_bytes(napot_top);
         end
         default: begin
            on_in = 1'b0;
         end
      endcase
   end

   // The decoded range is registered, so it follows each register change in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff <= 1'b0;
      end else begin
         on_ff <= on_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // The first entry holding the first byte decides.
   assign hit_here = on_ff && !in_item.done &&
                     (in_item.addr >= lo_ff) && (in_item.addr < hi_ff);

   always_comb begin
      if (in_item.last >= hi_ff) begin
         ok_here = 1'b0;
      end else if (!cfg_byte[CFG_L_BIT] && (in_item.eff == PRIV_M)) begin
         ok_here = 1'b1;
      end else if (in_item.kind == KIND_FETCH) begin
         ok_here = cfg_byte[CFG_X_BIT];
      end else if (in_item.kind == KIND_LOAD) begin
         ok_here = cfg_byte[CFG_R_BIT];
      end else begin
         ok_here = cfg_byte[CFG_W_BIT];
      end
   end

   always_comb begin
      item_in = in_item;
      if (hit_here) begin
         item_in.done = 1'b1;
         item_in.ok   = ok_here;
         item_in.hit  = HIT_W'(INDEX);
      end
   end

   // Stage register; it loads whenever it is empty or its word moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/pmp_access_check_top.sv -----
// Throughput: one access per cycle while rsp_tready holds high, set by the row
// of ENTRIES cells, each one register stage checking one protection entry;
// the request stream pauses in the cycle after each configuration write.
// Reset: synchronous, active high; all entries read as OFF and the row of
// cells is emptied. Requests are taken in the first cycle after reset.
//------------------------------------------------------------------------------
// pmp_access_check_top
// Physical memory protection check for one fetch, load or store per word.
//------------------------------------------------------------------------------
`default_nettype none

module pmp_access_check_top
   import pac_pkg::*;
#(
   parameter int ENTRIES = PAC_ENTRIES
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // tdata: byte_addr[31:0], access_size[35:32], run_priv[37:36],
   // data_priv[39:38]
   input  wire logic [39:0]       req_tdata,
   // tuser: kind[1:0]
   input  wire logic [1:0]        req_tuser,
   // Response channel.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // tdata: allowed[0], hit_entry[4:1], zero[7:5]
   output logic      [7:0]        rsp_tdata,
   // Configuration port.
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   pac_regs_type      regs;
   logic [ADDR_W-1:0] byte_addr;
   logic [SIZE_W-1:0] access_size;
   logic [PRIV_W-1:0] run_priv;
   logic [PRIV_W-1:0] data_priv;
   logic [ADDR_W-1:0] words [ENTRIES];
   pac_item_type      link_item  [ENTRIES+1];
   logic              link_valid [ENTRIES+1];
   logic              link_ready [ENTRIES+1];
   pac_item_type      final_item;
   logic              allowed;
   logic [HIT_W-1:0]  hit_entry;
   logic              cfg_hold_in;
   logic              cfg_hold_ff;

   pac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // Unpack the request word.
   assign byte_addr   = req_tdata[31:0];
   assign access_size = req_tdata[35:32];
   assign run_priv    = req_tdata[37:36];
   assign data_priv   = req_tdata[39:38];

   // Build the word entering the first cell.
   always_comb begin
      link_item[0].kind = req_tuser;
      link_item[0].addr = byte_addr;
      link_item[0].last = byte_addr + ADDR_W'(access_size) - ADDR_W'(1);
      link_item[0].eff  = (req_tuser == KIND_FETCH) ? run_priv : data_priv;
      link_item[0].done = 1'b0;
      link_item[0].ok   = 1'b0;
      link_item[0].hit  = NO_HIT;
   end

   // The cells refresh their decoded ranges in the cycle after a register
   // write, so the request stream pauses in that cycle.
   assign cfg_hold_in = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_hold_ff <= 1'b0;
      end else begin
         cfg_hold_ff <= cfg_hold_in;
      end
   end

   assign link_valid[0] = req_tvalid && !cfg_hold_ff;
   assign req_tready    = link_ready[0] && !cfg_hold_ff;

   // Row of cells, one per entry.
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      assign words[k] = regs.addr_pair[k/2][(k%2)*ADDR_W +: ADDR_W];

      pac_cell #(
         .INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg_byte  (regs.cfg_bytes[8*k +: 8]),
         .word      (words[k]),
         .prev_word ((k == 0) ? '0 : words[(k == 0) ? 0 : k-1]),
         .in_valid  (link_valid[k]),
         .in_item   (link_item[k]),
         .in_ready  (link_ready[k]),
         .out_valid (link_valid[k+1]),
         .out_item  (link_item[k+1]),
         .out_ready (link_ready[k+1])
      );
   end

   // The last cell's register is the response register.
   assign final_item         = link_item[ENTRIES];
   assign rsp_tvalid         = link_valid[ENTRIES];
   assign link_ready[ENTRIES] = rsp_tready;

   // With no matching entry only machine mode is permitted.
   assign allowed   = final_item.done ? final_item.ok : (final_item.eff == PRIV_M);
   assign hit_entry = final_item.hit;
   assign rsp_tdata = {3'b000, hit_entry, allowed};

endmodule

`default_nettype wire

// ----- verif/tb_pmp_access_check_top.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_pmp_access_check_top
// Self-checking bench for the PMP access check. A short table of directed
// accesses runs first, under the reset setting and under a hand-built set of
// entries. Randomized protection settings and accesses follow. Every response
// word is checked against its typed table row or an in-bench model of the
// entry decode and the permission rules, with random stalls on both streams.
//------------------------------------------------------------------------------

module tb_pmp_access_check_top;
   import pac_pkg::*;

   localparam int ENTRIES     = PAC_ENTRIES;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 125;
   localparam int DIR_ROWS    = 24;

   // Access kinds and privilege levels that the package leaves unnamed.
   localparam logic [KIND_W-1:0] KIND_STORE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;
   localparam logic [PRIV_W-1:0] PRIV_U     = 2'd0;
   localparam logic [PRIV_W-1:0] PRIV_S     = 2'd1;
   localparam logic [PRIV_W-1:0] PRIV_H     = 2'd2;

   // Permission bits of one entry configuration byte.
   localparam logic [2:0] PERM_NONE = 3'b000;
   localparam logic [2:0] PERM_R    = 3'b001;
   localparam logic [2:0] PERM_W    = 3'b010;
   localparam logic [2:0] PERM_X    = 3'b100;

   // Register indexes past the last address pair; writes there are ignored.
   localparam int REG_UNUSED_FIRST = 5;
   localparam int REG_UNUSED_LAST  = 7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic [PRIV_W-1:0] run_priv;
      logic [PRIV_W-1:0] data_priv;
   } access_type;

   typedef struct packed {
      logic             allowed;
      logic [HIT_W-1:0] hit;
   } verdict_type;

   typedef struct packed {
      logic              setting;
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic [PRIV_W-1:0] run_priv;
      logic [PRIV_W-1:0] data_priv;
      logic              typed;
      logic              allowed;
      logic [HIT_W-1:0]  hit;
   } dir_row_type;

   // Directed accesses. Setting 0 is the reset state, setting 1 the
   // hand-built entries loaded by load_directed_setting.
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{1'b0, KIND_FETCH, 32'h0000_0000, 4'd1,  PRIV_M, PRIV_U, 1'b1, 1'b1, NO_HIT},
      '{1'b0, KIND_LOAD,  32'hFFFF_FFFF, 4'd15, PRIV_M, PRIV_U, 1'b1, 1'b0, NO_HIT},
      '{1'b0, KIND_OTHER, 32'h8000_0000, 4'd8,  PRIV_U, PRIV_M, 1'b1, 1'b1, NO_HIT},
      '{1'b0, KIND_FETCH, 32'h5555_5555, 4'd0,  PRIV_H, PRIV_M, 1'b1, 1'b0, NO_HIT},
      '{1'b0, KIND_STORE, 32'hAAAA_AAAA, 4'd4,  PRIV_S, PRIV_S, 1'b1, 1'b0, NO_HIT},
      '{1'b0, KIND_LOAD,  32'h1234_5678, 4'd2,  PRIV_U, PRIV_M, 1'b1, 1'b1, NO_HIT},
      '{1'b1, KIND_FETCH, 32'h0000_0000, 4'd4,  PRIV_U, PRIV_M, 1'b1, 1'b0, 4'd0},
      '{1'b1, KIND_LOAD,  32'h0000_03FC, 4'd4,  PRIV_M, PRIV_U, 1'b1, 1'b1, 4'd0},
      '{1'b1, KIND_LOAD,  32'h0000_03FC, 4'd8,  PRIV_M, PRIV_U, 1'b1, 1'b0, 4'd0},
      '{1'b1, KIND_STORE, 32'h0000_0100, 4'd1,  PRIV_U, PRIV_M, 1'b1, 1'b1, 4'd0},
      '{1'b1, KIND_STORE, 32'h0000_0100, 4'd1,  PRIV_M, PRIV_H, 1'b1, 1'b0, 4'd0},
      '{1'b1, KIND_OTHER, 32'h0000_2000, 4'd4,  PRIV_M, PRIV_U, 1'b1, 1'b1, 4'd3},
      '{1'b1, KIND_LOAD,  32'h0000_2000, 4'd4,  PRIV_U, PRIV_M, 1'b1, 1'b0, 4'd3},
      '{1'b1, KIND_FETCH, 32'h0000_1000, 4'd4,  PRIV_U, PRIV_M, 1'b1, 1'b1, 4'd2},
      '{1'b1, KIND_FETCH, 32'h0000_1002, 4'd4,  PRIV_U, PRIV_M, 1'b1, 1'b0, 4'd2},
      '{1'b1, KIND_FETCH, 32'hFFFF_FFFF, 4'd1,  PRIV_M, PRIV_U, 1'b1, 1'b1, NO_HIT},
      '{1'b1, KIND_LOAD,  32'hFFFF_FFFF, 4'd1,  PRIV_M, PRIV_H, 1'b1, 1'b0, NO_HIT},
      '{1'b1, KIND_STORE, 32'hFFFF_FFFC, 4'd8,  PRIV_U, PRIV_S, 1'b0, 1'b0, 4'd0},
      '{1'b1, KIND_STORE, 32'h0000_0000, 4'd0,  PRIV_U, PRIV_M, 1'b1, 1'b0, 4'd0},
      '{1'b1, KIND_LOAD,  32'h0000_03F0, 4'd15, PRIV_U, PRIV_S, 1'b0, 1'b0, 4'd0},
      '{1'b1, KIND_OTHER, 32'h0000_0600, 4'd2,  PRIV_M, PRIV_M, 1'b0, 1'b0, 4'd0},
      '{1'b1, KIND_FETCH, 32'h0000_0FFF, 4'd2,  PRIV_S, PRIV_U, 1'b0, 1'b0, 4'd0},
      '{1'b1, KIND_STORE, 32'hFFFF_FFFE, 4'd2,  PRIV_U, PRIV_U, 1'b0, 1'b0, 4'd0},
      '{1'b1, KIND_FETCH, 32'h0000_1003, 4'd1,  PRIV_M, PRIV_U, 1'b0, 1'b0, 4'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Shadow copy of the protection registers.
   logic [CSR_DW-1:0] cfg_shadow = '0;
   logic [CSR_DW-1:0] pair_shadow [PAIRS] = '{default: '0};

   // Byte bounds of the current entries, used to aim random accesses.
   logic [ADDR_W-1:0] range_edges [$];

   verdict_type pending_verdicts [$];
   logic        full_rate = 1'b0;
   int          ready_left = 0;
   int          error_count = 0;
   int          words_checked = 0;
   int          permit_count = 0;
   int          deny_count = 0;
   int          miss_count = 0;
   int          setting_count = 1;
   int          kind_count [4] = '{default: 0};

   pmp_access_check_top #(.ENTRIES(ENTRIES)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #6_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   //---------------------------------------------------------------------------
   // Model of the protection check
   //---------------------------------------------------------------------------

   // A word bound at or above 2^30 saturates to the top byte.
   function automatic logic [ADDR_W-1:0] word_to_byte(input logic [63:0] words);
      if (words >= (64'd1 << WORD_LIMIT_SHIFT)) return TOP_BYTE;
      return {words[WORD_LIMIT_SHIFT-1:0], 2'b00};
   endfunction

   function automatic logic [63:0] entry_word(input int k);
      logic [CSR_DW-1:0] pair;
      pair = pair_shadow[k / 2];
      return (k % 2 == 1) ? {32'd0, pair[63:32]} : {32'd0, pair[31:0]};
   endfunction

   // Decodes entry k into the byte range [lo, hi); valid is low when the
   // entry is off or is an empty or inverted TOR.
   function automatic void entry_range(input int k, output logic valid,
                                       output logic [ADDR_W-1:0] lo,
                                       output logic [ADDR_W-1:0] hi);
      logic [63:0]  w;
      logic [63:0]  prev;
      logic [63:0]  span;
      logic [63:0]  base;
      int           ones;
      pac_mode_type mode;
      mode  = pac_mode_type'(cfg_shadow[8*k+3 +: 2]);
      w     = entry_word(k);
      valid = 1'b1;
      lo    = '0;
      hi    = '0;
      case (mode)
         MODE_TOR: begin
            prev = (k == 0) ? 64'd0 : entry_word(k - 1);
            if (w <= prev) begin
               valid = 1'b0;
            end else begin
               lo = word_to_byte(prev);
               hi = word_to_byte(w);
            end
         end
         MODE_NA4: begin
            lo = word_to_byte(w);
            hi = word_to_byte(w + 64'd1);
         end
         MODE_NAPOT: begin
            ones = 0;
            while (ones < 31 && w[ones]) ones++;
            span = 64'd1 << (ones + 1);
            base = w & ~(span - 64'd1);
            lo   = word_to_byte(base);
            hi   = word_to_byte(base + span);
         end
         default: valid = 1'b0;
      endcase
   endfunction

   // The lowest entry holding the first byte decides; no match leaves
   // only M-mode allowed.
   function automatic verdict_type judge_access(input access_type acc);
      verdict_type       v;
      logic [ADDR_W-1:0] last;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [PRIV_W-1:0] eff;
      logic [7:0]        cfg;
      logic              valid;
      logic              found;
      logic              perm;
      int                k;
      last      = acc.addr + {28'd0, acc.size} - 32'd1;
      eff       = (acc.kind == KIND_FETCH) ? acc.run_priv : acc.data_priv;
      v.allowed = (eff == PRIV_M);
      v.hit     = NO_HIT;
      found     = 1'b0;
      for (k = 0; k < ENTRIES; k++) begin
         if (!found) begin
            cfg = cfg_shadow[8*k +: 8];
            entry_range(k, valid, lo, hi);
            if (valid && acc.addr >= lo && acc.addr < hi) begin
               found = 1'b1;
               v.hit = HIT_W'(k);
               case (acc.kind)
                  KIND_FETCH: perm = cfg[CFG_X_BIT];
                  KIND_LOAD:  perm = cfg[CFG_R_BIT];
                  default:    perm = cfg[CFG_W_BIT];
               endcase
               if (last >= hi) begin
                  v.allowed = 1'b0;
               end else if (!cfg[CFG_L_BIT] && eff == PRIV_M) begin
                  v.allowed = 1'b1;
               end else begin
                  v.allowed = perm;
               end
            end
         end
      end
      return v;
   endfunction

   function automatic void refresh_edges();
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic              valid;
      int                k;
      range_edges.delete();
      range_edges.push_back('0);
      range_edges.push_back(TOP_BYTE);
      for (k = 0; k < ENTRIES; k++) begin
         entry_range(k, valid, lo, hi);
         if (valid) begin
            range_edges.push_back(lo);
            range_edges.push_back(hi);
         end
      end
   endfunction

   //---------------------------------------------------------------------------
   // Configuration port
   //---------------------------------------------------------------------------

   // A setup phase and an access phase, then the bus goes idle.
   task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                               input logic [CSR_DW-1:0] wdata,
                               output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Writes a register, mirrors it in the shadow and, for the used indexes, reads it back.
   task automatic write_register(input logic [2:0] idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] back;
      apb_transfer(1'b1, idx, value, back);
      case (idx)
         REG_CFG_BYTES:  cfg_shadow     = value;
         REG_ADDR_PAIR0: pair_shadow[0] = value;
         REG_ADDR_PAIR1: pair_shadow[1] = value;
         REG_ADDR_PAIR2: pair_shadow[2] = value;
         REG_ADDR_PAIR3: pair_shadow[3] = value;
         default: ;
      endcase
      if (idx <= REG_ADDR_PAIR3) begin
         apb_transfer(1'b0, idx, '0, back);
         if (back !== value) begin
            flag_error($sformatf("register %0d reads %h, written %h", idx, back, value));
         end
      end
      refresh_edges();
   endtask

   function automatic logic [7:0] entry_cfg(input logic lock, input pac_mode_type mode,
                                            input logic [2:0] perms);
      return {lock, 2'b00, mode, perms};
   endfunction

   // Hand-built entries: a TOR from zero, an inverted TOR, a locked NA4,
   // a saturated NAPOT over the whole space, an empty TOR and a few spares.
   task automatic load_directed_setting();
      int j;
      for (j = REG_UNUSED_FIRST; j <= REG_UNUSED_LAST; j++) begin
         write_register(3'(j), {$urandom, $urandom});
      end
      write_register(REG_CFG_BYTES, {entry_cfg(1'b0, MODE_NAPOT, PERM_R | PERM_W | PERM_X),
                                     entry_cfg(1'b0, MODE_NA4, PERM_R | PERM_W | PERM_X),
                                     entry_cfg(1'b0, MODE_TOR, PERM_R | PERM_W),
                                     entry_cfg(1'b0, MODE_OFF, PERM_NONE),
                                     entry_cfg(1'b1, MODE_NAPOT, PERM_W),
                                     entry_cfg(1'b1, MODE_NA4, PERM_X),
                                     entry_cfg(1'b1, MODE_TOR, PERM_R | PERM_W | PERM_X),
                                     entry_cfg(1'b0, MODE_TOR, PERM_R)});
      write_register(REG_ADDR_PAIR0, {32'h0000_0080, 32'h0000_0100});
      write_register(REG_ADDR_PAIR1, {32'hFFFF_FFFF, 32'h0000_0400});
      write_register(REG_ADDR_PAIR2, {32'h0000_0500, 32'h0000_0500});
      write_register(REG_ADDR_PAIR3, {32'h0000_0007, 32'h3FFF_FFFF});
      setting_count++;
   endtask

   task automatic load_uniform_setting(input logic [CSR_DW-1:0] cfg_value,
                                       input logic [CSR_DW-1:0] pair_value);
      write_register(REG_CFG_BYTES, cfg_value);
      write_register(REG_ADDR_PAIR0, pair_value);
      write_register(REG_ADDR_PAIR1, pair_value);
      write_register(REG_ADDR_PAIR2, pair_value);
      write_register(REG_ADDR_PAIR3, pair_value);
      setting_count++;
   endtask

   // Word addresses: small steps so TOR ranges chain (sometimes empty or
   // inverted), NAPOT patterns, values around 2^30 and the all-ones word.
   function automatic logic [31:0] pick_word(input logic [31:0] prev);
      int n;
      n = $urandom_range(0, 31);
      case ($urandom_range(0, 9))
         0, 1, 2: return prev + $urandom_range(0, 64);
         3:       return prev - $urandom_range(1, 64);
         4:       return $urandom;
         5:       return 32'h3FFF_FFF0 + $urandom_range(0, 32);
         6, 7:    return ($urandom << (n + 1)) | ((32'd1 << n) - 32'd1);
         8:       return 32'hFFFF_FFFF;
         default: return prev + $urandom_range(1, 32'h4000);
      endcase
   endfunction

   task automatic load_random_setting();
      logic [31:0] words [8];
      logic [31:0] prev;
      int          k;
      prev = '0;
      for (k = 0; k < 8; k++) begin
         words[k] = pick_word(prev);
         prev     = words[k];
      end
      write_register(REG_CFG_BYTES, {$urandom, $urandom});
      write_register(REG_ADDR_PAIR0, {words[1], words[0]});
      write_register(REG_ADDR_PAIR1, {words[3], words[2]});
      write_register(REG_ADDR_PAIR2, {words[5], words[4]});
      write_register(REG_ADDR_PAIR3, {words[7], words[6]});
      setting_count++;
   endtask

   //---------------------------------------------------------------------------
   // Request stream
   //---------------------------------------------------------------------------

   // Most accesses land on or next to an entry bound.
   function automatic access_type random_access();
      access_type acc;
      int         r;
      int         v;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         acc.addr = range_edges[$urandom_range(0, range_edges.size() - 1)]
                    + $urandom_range(0, 16) - 8;
      end else if (r == 6) begin
         acc.addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      end else begin
         acc.addr = $urandom;
      end
      if ($urandom_range(0, 9) < 7) begin
         acc.size = SIZE_W'(1 << $urandom_range(0, 3));
      end else begin
         acc.size = SIZE_W'($urandom_range(0, 15));
      end
      v = $urandom_range(0, 7);
      acc.kind      = (v == 7) ? KIND_OTHER : KIND_W'(v % 3);
      acc.run_priv  = PRIV_W'($urandom_range(0, 3));
      acc.data_priv = PRIV_W'($urandom_range(0, 3));
      return acc;
   endfunction

   // Starts and ends at a rising edge; valid stays high between back-to-back
   // words.
   task automatic issue_access(input access_type acc, input verdict_type verdict);
      int gap;
      gap = full_rate ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {acc.data_priv, acc.run_priv, acc.size, acc.addr};
      req_tuser  <= acc.kind;
      do @(posedge clock); while (!req_tready);
      pending_verdicts.push_back(verdict);
      kind_count[acc.kind]++;
   endtask

   // Stops sending and waits until every response word has come back.
   task automatic drain_accesses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   //---------------------------------------------------------------------------
   // Response stream: random back-pressure and checking
   //---------------------------------------------------------------------------
   always @(posedge clock) begin : response_side
      verdict_type want;
      int          stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               flag_error($sformatf("response word %h with no access outstanding",
                                    rsp_tdata));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tdata[0] !== want.allowed) begin
                  flag_error($sformatf("word %0d: allowed %b, expected %b",
                                       words_checked, rsp_tdata[0], want.allowed));
               end
               if (rsp_tdata[4:1] !== want.hit) begin
                  flag_error($sformatf("word %0d: hit_entry %0d, expected %0d",
                                       words_checked, rsp_tdata[4:1], want.hit));
               end
               if (rsp_tdata[7:5] !== 3'b000) begin
                  flag_error($sformatf("word %0d: padding bits %b", words_checked,
                                       rsp_tdata[7:5]));
               end
               if (want.hit == NO_HIT) miss_count++;
               if (want.allowed) permit_count++;
               else deny_count++;
            end
            words_checked++;
         end
         if (full_rate) begin
            rsp_tready <= 1'b1;
            ready_left <= 0;
         end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
               ready_left <= $urandom_range(0, 23);
            end else begin
               rsp_tready <= 1'b0;
               ready_left <= stall - 1;
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Test sequence
   //---------------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type row;
      access_type  acc;
      logic        cur_setting;
      int          i;
      int          phase;
      int          n;

      refresh_edges();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table; typed rows carry their own expectation.
      cur_setting = 1'b0;
      for (i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.setting != cur_setting) begin
            drain_accesses();
            load_directed_setting();
            cur_setting = row.setting;
         end
         acc = '{kind: row.kind, addr: row.addr, size: row.size,
                 run_priv: row.run_priv, data_priv: row.data_priv};
         if (row.typed) begin
            issue_access(acc, '{allowed: row.allowed, hit: row.hit});
         end else begin
            issue_access(acc, judge_access(acc));
         end
      end

      // Random settings, the all-zero and all-one extremes first.
      for (phase = 0; phase < PHASES; phase++) begin
         drain_accesses();
         case (phase)
            0:       load_uniform_setting('0, '0);
            1:       load_uniform_setting('1, '1);
            default: load_random_setting();
         endcase
         full_rate <= (phase == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Let the pipeline run empty once in the middle of a setting.
            if (phase == 5 && n == PHASE_ITEMS / 2) drain_accesses();
            acc = random_access();
            issue_access(acc, judge_access(acc));
         end
      end

      drain_accesses();
      repeat (4 * ENTRIES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", pending_verdicts.size()));
      end

      $display("Checked %0d response words over %0d protection settings:", words_checked,
               setting_count);
      $display("  %0d permitted, %0d denied, %0d without a matching entry; kinds %0d/%0d/%0d/%0d",
               permit_count, deny_count, miss_count, kind_count[0], kind_count[1],
               kind_count[2], kind_count[3]);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pac_pkg.sv
rtl/core/pac_csr.sv
rtl/core/pac_cell.sv
rtl/core/pmp_access_check_top.sv
verif/tb_pmp_access_check_top.sv
